[design/numeric_text_token_checker_top_defines.svh]
// Assertion macros for the numeric text token checker verification files.
// Depends on nothing; included by the checker module file.
`ifndef NUMERIC_TEXT_TOKEN_CHECKER_TOP_DEFINES_SVH
`define NUMERIC_TEXT_TOKEN_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low
`define NTC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ntc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while reset is low
`define NTC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ntc: next-cycle check failed");

`endif

[design/ntc_pkg.sv]
// Shared constants and types for the numeric text token checker.
// Character codes, lexer state codes and the lexer step result struct.
`default_nettype none

package ntc_pkg;

    // Character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Lexer state codes
    localparam int unsigned STATE_W = 4;
    localparam logic [STATE_W-1:0] ST_OUT      = 4'd0;
    localparam logic [STATE_W-1:0] ST_SIGN     = 4'd1;
    localparam logic [STATE_W-1:0] ST_ZERO     = 4'd2;
    localparam logic [STATE_W-1:0] ST_INT      = 4'd3;
    localparam logic [STATE_W-1:0] ST_POINT    = 4'd4;
    localparam logic [STATE_W-1:0] ST_FRAC     = 4'd5;
    localparam logic [STATE_W-1:0] ST_EXP      = 4'd6;
    localparam logic [STATE_W-1:0] ST_EXP_SIGN = 4'd7;
    localparam logic [STATE_W-1:0] ST_EXP_DIG  = 4'd8;
    localparam logic [STATE_W-1:0] ST_COMMENT  = 4'd9;
    localparam logic [STATE_W-1:0] ST_ERROR    = 4'd10;

    // Result of one lexer step
    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic               keep;
        logic               done;
        logic               abort_tok;
    } ntc_step_t;

endpackage

`default_nettype wire

[design/numeric_text_token_checker_top.sv]
// Path: an accepted item passes the input register, then the result register;
// m_ready low can hold it in either stage.
// Throughput: one item per cycle while m_ready does not stall the result stage.
// Reset (aresetn low, synchronous): both stages empty, lexer outside any token.
// Depends on ntc_pkg and ntc_lexer.
`default_nettype none

module numeric_text_token_checker_top
    import ntc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_char_out,
    output logic            m_keep_char,
    output logic            m_token_done,
    output logic            m_token_abort,
    output logic            m_error
);

    logic               in_valid_reg;
    logic [7:0]         in_char_reg;
    logic [STATE_W-1:0] lex_state_reg;
    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic               out_keep_reg;
    logic               out_done_reg;
    logic               out_abort_reg;
    logic               out_error_reg;
    logic               advance;
    ntc_step_t          step;

    // Move the held item into the result register when there is room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ntc_lexer u_lexer (
        .state_in (lex_state_reg),
        .char_in  (in_char_reg),
        .step_out (step)
    );

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
        end
    end

    // Lexer state advances once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lex_state_reg <= ST_OUT;
        end else if (advance) begin
            lex_state_reg <= step.next_state;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_char_reg  <= in_char_reg;
            out_keep_reg  <= step.keep;
            out_done_reg  <= step.done;
            out_abort_reg <= step.abort_tok;
            out_error_reg <= (step.next_state == ST_ERROR);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_char_out    = out_char_reg;
    assign m_keep_char   = out_keep_reg;
    assign m_token_done  = out_done_reg;
    assign m_token_abort = out_abort_reg;
    assign m_error       = out_error_reg;

endmodule

`default_nettype wire

[design/ntc_lexer.sv]
// Combinational lexer step: current state and one byte in, next state and flags out.
// Depends on ntc_pkg.
`default_nettype none

module ntc_lexer
    import ntc_pkg::*;
(
    input  wire logic [STATE_W-1:0] state_in,
    input  wire logic [7:0]         char_in,
    output ntc_step_t               step_out
);

    logic is_delim;
    logic is_digit;
    logic tok_complete;
    logic tok_pending;

    // Character and state classes
    always_comb begin
        is_delim     = char_in inside {CH_COMMA, CH_SPACE, CH_TAB, CH_LF, CH_CR};
        is_digit     = char_in inside {[CH_0:CH_9]};
        tok_complete = state_in inside {ST_ZERO, ST_INT, ST_FRAC, ST_EXP_DIG};
        tok_pending  = state_in inside {[ST_SIGN:ST_EXP_DIG]};
    end

    // Transition table
    always_comb begin
        step_out.next_state = state_in;
        step_out.keep       = 1'b0;
        step_out.done       = 1'b0;
        step_out.abort_tok  = 1'b0;

        if (state_in > ST_COMMENT) begin
            // error state and unused codes
            step_out.next_state = ST_ERROR;
        end else if (char_in == CH_HASH) begin
            step_out.abort_tok  = tok_pending;
            step_out.next_state = ST_COMMENT;
        end else if (state_in == ST_COMMENT) begin
            if (char_in == CH_LF || char_in == CH_CR) begin
                step_out.next_state = ST_OUT;
            end
        end else if (is_delim) begin
            if (tok_complete) begin
                step_out.done       = 1'b1;
                step_out.next_state = ST_OUT;
            end else if (state_in != ST_OUT) begin
                step_out.next_state = ST_ERROR;
            end
        end else if (is_digit) begin
            step_out.keep = 1'b1;
            case (state_in)
                ST_OUT, ST_SIGN: begin
                    step_out.next_state = (char_in == CH_0) ? ST_ZERO : ST_INT;
                end
                ST_POINT: begin
                    step_out.next_state = ST_FRAC;
                end
                ST_EXP, ST_EXP_SIGN: begin
                    step_out.next_state = ST_EXP_DIG;
                end
                ST_ZERO: begin
                    // digit after a leading zero
                    step_out.keep       = 1'b0;
                    step_out.next_state = ST_ERROR;
                end
                default: begin
                    // integer, fraction and exponent digits hold their state
                    step_out.next_state = state_in;
                end
            endcase
        end else if (char_in == CH_POINT) begin
            if (state_in == ST_INT || state_in == ST_ZERO) begin
                step_out.keep       = 1'b1;
                step_out.next_state = ST_POINT;
            end else begin
                step_out.next_state = ST_ERROR;
            end
        end else if (char_in == CH_E) begin
            if (state_in == ST_INT || state_in == ST_FRAC) begin
                step_out.keep       = 1'b1;
                step_out.next_state = ST_EXP;
            end else begin
                step_out.next_state = ST_ERROR;
            end
        end else if (char_in == CH_MINUS) begin
            if (state_in == ST_OUT) begin
                step_out.keep       = 1'b1;
                step_out.next_state = ST_SIGN;
            end else if (state_in == ST_EXP) begin
                step_out.keep       = 1'b1;
                step_out.next_state = ST_EXP_SIGN;
            end else begin
                step_out.next_state = ST_ERROR;
            end
        end else if (char_in == CH_PLUS) begin
            if (state_in == ST_EXP) begin
                step_out.keep       = 1'b1;
                step_out.next_state = ST_EXP_SIGN;
            end else begin
                step_out.next_state = ST_ERROR;
            end
        end else begin
            step_out.next_state = ST_ERROR;
        end
    end

endmodule

`default_nettype wire

[design/ntc_checker.sv]
// Port-level checks for numeric_text_token_checker_top, attached by bind.
// Depends on ntc_pkg and numeric_text_token_checker_top_defines.svh.
`default_nettype none
`include "numeric_text_token_checker_top_defines.svh"

module ntc_checker
    import ntc_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_char_out,
    input wire logic       m_keep_char,
    input wire logic       m_token_done,
    input wire logic       m_token_abort,
    input wire logic       m_error
);

    logic err_seen_reg;
    logic in_acc;
    logic out_acc;
    logic out_is_delim;
    logic out_flags;
    logic fill_start;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Byte and flag classes of the shown result
    assign out_is_delim = (m_char_out == CH_COMMA) || (m_char_out == CH_SPACE) ||
                          (m_char_out == CH_TAB) || (m_char_out == CH_LF) ||
                          (m_char_out == CH_CR);
    assign out_flags    = m_keep_char || m_token_done || m_token_abort;
    assign fill_start   = in_acc && !m_valid && s_ready;

    // Remember a delivered error item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_seen_reg <= 1'b0;
        end else if (out_acc && m_error) begin
            err_seen_reg <= 1'b1;
        end
    end

    // Error is sticky across items
    `NTC_ASSERT_IMPL(a_error_sticky, aclk, aresetn, m_valid && err_seen_reg, m_error)
    // An error item carries no token flags
    `NTC_ASSERT_IMPL(a_error_quiet, aclk, aresetn, m_valid && m_error, !out_flags)
    // Token done only on a delimiter byte
    `NTC_ASSERT_IMPL(a_done_delim, aclk, aresetn, m_valid && m_token_done, out_is_delim)
    // Token abort only on a comment start
    `NTC_ASSERT_IMPL(a_abort_hash, aclk, aresetn, m_valid && m_token_abort, m_char_out == CH_HASH)
    // An item accepted into an empty block passes the input and result registers before m_valid rises
    `NTC_ASSERT_NEXT(a_fill_latency, aclk, aresetn, fill_start && !$past(in_acc), ##1 m_valid)

endmodule

bind numeric_text_token_checker_top ntc_checker u_ntc_checker (.*);

`default_nettype wire
